### hw/rtl/gbts_pkg.sv
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared widths, codes and types of the gap-buffer text store.
// ----------------------------------------------------------------------------
package gbts_pkg;

  localparam int DEF_CAPACITY = 4096;
  localparam int DEF_MAX_READ = 64;

  localparam int ACTION_W = 2;
  localparam int LEN_W    = 13;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;

  // move cells between the read port and the write port
  localparam int CHAIN_LEN = 2;
  // cell that picks up the registered read data
  localparam int DATA_CELL = 1;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic valid;
    logic is_read;
    logic last;
  } cell_ctl_t;

endpackage

### hw/rtl/gbts_cmd_if.sv
// ----------------------------------------------------------------------------
// gbts_cmd_if
// Command channel: one edit or read request per transaction.
// ----------------------------------------------------------------------------
interface gbts_cmd_if;
  import gbts_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [LEN_W-1:0]    position;
  logic [BYTE_W-1:0]   char_byte;
  logic [LEN_W-1:0]    count;

  modport source (output valid, output action, output position, output char_byte,
                  output count, input ready);
  modport sink   (input valid, input action, input position, input char_byte,
                  input count, output ready);
endinterface

### hw/rtl/gbts_rsp_if.sv
// ----------------------------------------------------------------------------
// gbts_rsp_if
// Response channel: one result per transaction.
// ----------------------------------------------------------------------------
interface gbts_rsp_if;
  import gbts_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   read_byte;
  logic [STATUS_W-1:0] status;
  logic [LEN_W-1:0]    text_length;
  logic                last;

  modport source (output valid, output read_byte, output status, output text_length,
                  output last, input ready);
  modport sink   (input valid, input read_byte, input status, input text_length,
                  input last, output ready);
endinterface

### hw/rtl/gbts_store.sv
// ----------------------------------------------------------------------------
// gbts_store
// Byte store of the text: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gbts_store #(
  parameter int DEPTH  = gbts_pkg::DEF_CAPACITY,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [gbts_pkg::BYTE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [gbts_pkg::BYTE_W-1:0] rd_data
);
  import gbts_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/gbts_cell.sv
// ----------------------------------------------------------------------------
// gbts_cell
// One move cell: carries a byte token, its target address and data one step.
// ----------------------------------------------------------------------------
module gbts_cell #(
  parameter int ADDR_W = $clog2(gbts_pkg::DEF_CAPACITY)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  gbts_pkg::cell_ctl_t         ctl_in,
  input  logic [ADDR_W-1:0]           dst_in,
  input  logic [gbts_pkg::BYTE_W-1:0] data_in,
  output gbts_pkg::cell_ctl_t         ctl_out,
  output logic [ADDR_W-1:0]           dst_out,
  output logic [gbts_pkg::BYTE_W-1:0] data_out
);
  import gbts_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    dst_out  <= dst_in;
    data_out <= data_in;
  end

endmodule

### hw/rtl/gap_buffer_text_store.sv
// ----------------------------------------------------------------------------
// gap_buffer_text_store
// Fixed-capacity gap-buffer text store with insert, delete and read commands.
// ----------------------------------------------------------------------------
// Commands arrive on cmd (valid/ready), results leave on rsp (valid/ready).
// Insert and delete give one result; a read gives one result per byte, up
// to MAX_READ, with last set on the final one; an empty read gives one
// result with status empty. An insert into a full store is dropped.
// One command is worked on at a time. An insert or delete first moves the
// gap to the position: the move cells shift one byte per cycle from the read
// port of the store to its write port, and the cell chain is drained before
// the edit completes. A read fetches one byte at a time: a byte is read
// only when the cells are empty and the result register is free; it passes
// the registered read of the store, the cells and the result register.
// The result register parts the channels: a new command is taken while a
// finished result waits; a stalled receiver holds the result and holds
// back further results of the running command.
// Reset (synchronous) empties the text: gap over the whole store. The
// store itself is not cleared; only written bytes are ever read back.
// ----------------------------------------------------------------------------
module gap_buffer_text_store #(
  parameter int CAPACITY = gbts_pkg::DEF_CAPACITY,
  parameter int MAX_READ = gbts_pkg::DEF_MAX_READ
) (
  input  logic       clk,
  input  logic       rst,
  gbts_cmd_if.sink   cmd,
  gbts_rsp_if.source rsp
);
  import gbts_pkg::*;

  localparam int AW     = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int RW     = $clog2(MAX_READ + 1);
  localparam int W      = (AW > LEN_W) ? AW : LEN_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_MOVE   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0]          state;
  logic [AW-1:0]       gap_begin;
  logic [AW-1:0]       gap_finish;
  logic [ACTION_W-1:0] act;
  logic [AW-1:0]       pos_c;
  logic [BYTE_W-1:0]   ch;
  logic [LEN_W-1:0]    cnt;
  logic [AW-1:0]       del_cnt;
  logic [AW-1:0]       rd_log;
  logic [RW-1:0]       rd_left;
  logic [STATUS_W-1:0] res_status;

  logic                rsp_valid;
  logic [BYTE_W-1:0]   out_byte;
  logic [STATUS_W-1:0] out_status;
  logic [LEN_W-1:0]    out_len;
  logic                out_last;

  logic [AW-1:0]       text_len;
  logic [W-1:0]        text_len_w;
  logic [W-1:0]        pos_w;
  logic [AW-1:0]       pos_clamped;
  logic [AW-1:0]       remain;
  logic [AW-1:0]       del_clamped;
  logic [W-1:0]        del_w;
  logic [RW-1:0]       rd_clamped;
  logic [AW-1:0]       gap_size;
  logic [AW-1:0]       phys;
  logic [AW-1:0]       rd_addr_w;
  logic [AW-1:0]       dst_w;
  cell_ctl_t           issue_ctl;
  logic                chain_empty;
  logic                rd_issue;

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [BYTE_W-1:0]   wr_data;
  logic [BYTE_W-1:0]   mem_q;

  cell_ctl_t           ctl_chain  [CHAIN_LEN+1];
  logic [ADDR_W-1:0]   dst_chain  [CHAIN_LEN+1];
  logic [BYTE_W-1:0]   data_chain [CHAIN_LEN+1];

  assign cmd.ready       = (state == S_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.read_byte   = out_byte;
  assign rsp.status      = out_status;
  assign rsp.text_length = out_len;
  assign rsp.last        = out_last;

  assign gap_size   = gap_finish - gap_begin;
  assign text_len   = AW'(CAPACITY) - gap_size;
  assign text_len_w = W'(text_len);

  // position clamp at acceptance
  assign pos_w       = W'(cmd.position);
  assign pos_clamped = (pos_w > text_len_w) ? text_len : pos_w[AW-1:0];

  // count clamps once the position is registered
  assign remain      = text_len - pos_c;
  assign del_clamped = (W'(cnt) > W'(remain)) ? remain : AW'(cnt);
  assign del_w       = W'(del_clamped);
  assign rd_clamped  = (del_w > W'(MAX_READ)) ? RW'(MAX_READ) : del_w[RW-1:0];

  assign phys = (rd_log < gap_begin) ? rd_log : rd_log + gap_size;

  always_comb begin
    chain_empty = 1'b1;
    for (int k = 1; k <= CHAIN_LEN; k++) begin
      if (ctl_chain[k].valid) begin
        chain_empty = 1'b0;
      end
    end
  end

  assign rd_issue = (state == S_READ) && chain_empty && !rsp_valid;

  always_comb begin
    issue_ctl = '0;
    rd_addr_w = '0;
    dst_w     = '0;
    unique case (state)
      S_MOVE: begin
        if (gap_begin != pos_c) begin
          issue_ctl.valid = 1'b1;
          if (pos_c < gap_begin) begin
            rd_addr_w = gap_begin - AW'(1);
            dst_w     = gap_finish - AW'(1);
          end else begin
            rd_addr_w = gap_finish;
            dst_w     = gap_begin;
          end
        end
      end
      S_READ: begin
        if (rd_issue) begin
          issue_ctl.valid   = 1'b1;
          issue_ctl.is_read = 1'b1;
          issue_ctl.last    = (rd_left == RW'(1));
          rd_addr_w         = phys;
        end
      end
      default: begin
      end
    endcase
  end

  // store writes: shifted bytes from the tail cell, else the inserted byte
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = gap_begin[ADDR_W-1:0];
    wr_data = ch;
    if (ctl_chain[CHAIN_LEN].valid && !ctl_chain[CHAIN_LEN].is_read) begin
      wr_en   = 1'b1;
      wr_addr = dst_chain[CHAIN_LEN];
      wr_data = data_chain[CHAIN_LEN];
    end else if (state == S_DRAIN && chain_empty && act == ACT_INSERT) begin
      wr_en = 1'b1;
    end
  end

  gbts_store #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr_w[ADDR_W-1:0]),
    .rd_data (mem_q)
  );

  assign ctl_chain[0]  = issue_ctl;
  assign dst_chain[0]  = dst_w[ADDR_W-1:0];
  assign data_chain[0] = '0;

  for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_cell
    logic [BYTE_W-1:0] cell_data_in;
    if (k == DATA_CELL) begin : g_load
      assign cell_data_in = mem_q;
    end else begin : g_pass
      assign cell_data_in = data_chain[k];
    end

    gbts_cell #(
      .ADDR_W (ADDR_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl_in   (ctl_chain[k]),
      .dst_in   (dst_chain[k]),
      .data_in  (cell_data_in),
      .ctl_out  (ctl_chain[k+1]),
      .dst_out  (dst_chain[k+1]),
      .data_out (data_chain[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      gap_begin  <= '0;
      gap_finish <= AW'(CAPACITY);
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      // a read byte reaches the tail cell only when the result register is free
      if (ctl_chain[CHAIN_LEN].valid && ctl_chain[CHAIN_LEN].is_read) begin
        rsp_valid  <= 1'b1;
        out_byte   <= data_chain[CHAIN_LEN];
        out_status <= STATUS_OK;
        out_len    <= text_len_w[LEN_W-1:0];
        out_last   <= ctl_chain[CHAIN_LEN].last;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            act   <= cmd.action;
            pos_c <= pos_clamped;
            ch    <= cmd.char_byte;
            cnt   <= cmd.count;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          rd_log     <= pos_c;
          rd_left    <= rd_clamped;
          del_cnt    <= del_clamped;
          res_status <= STATUS_OK;
          case (act)
            ACT_INSERT: begin
              if (gap_begin == gap_finish) begin
                res_status <= STATUS_FULL;
                state      <= S_RESULT;
              end else begin
                state <= S_MOVE;
              end
            end
            ACT_DELETE: begin
              state <= S_MOVE;
            end
            ACT_READ: begin
              if (rd_clamped == '0) begin
                res_status <= STATUS_EMPTY;
                state      <= S_RESULT;
              end else begin
                state <= S_READ;
              end
            end
            default: begin
              state <= S_RESULT;
            end
          endcase
        end
        S_MOVE: begin
          if (gap_begin == pos_c) begin
            state <= S_DRAIN;
          end else if (pos_c < gap_begin) begin
            gap_begin  <= gap_begin - AW'(1);
            gap_finish <= gap_finish - AW'(1);
          end else begin
            gap_begin  <= gap_begin + AW'(1);
            gap_finish <= gap_finish + AW'(1);
          end
        end
        S_DRAIN: begin
          if (chain_empty) begin
            if (act == ACT_INSERT) begin
              gap_begin <= gap_begin + AW'(1);
            end else if (act == ACT_DELETE) begin
              gap_finish <= gap_finish + del_cnt;
            end
            state <= (act == ACT_READ) ? S_IDLE : S_RESULT;
          end
        end
        S_READ: begin
          if (rd_issue) begin
            rd_log  <= rd_log + AW'(1);
            rd_left <= rd_left - RW'(1);
            if (rd_left == RW'(1)) begin
              state <= S_DRAIN;
            end
          end
        end
        S_RESULT: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            out_byte   <= '0;
            out_status <= res_status;
            out_len    <= text_len_w[LEN_W-1:0];
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/gbts_checker.sv
// ----------------------------------------------------------------------------
// gbts_checker
// Port-level checks of the gap-buffer text store, bound to the top level.
// ----------------------------------------------------------------------------
module gbts_checker #(
  parameter int CAPACITY = gbts_pkg::DEF_CAPACITY
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [gbts_pkg::BYTE_W-1:0]   read_byte,
  input logic [gbts_pkg::STATUS_W-1:0] status,
  input logic [gbts_pkg::LEN_W-1:0]    text_length,
  input logic                          last
);
  import gbts_pkg::*;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_byte) && $stable(status)
      && $stable(text_length) && $stable(last))
    else $error("stalled result changed");

  // one command at a time: busy right after a transaction on cmd
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while busy");

  // full and empty results close the command and carry no byte
  a_status_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != STATUS_OK |-> last && read_byte == '0)
    else $error("status result not final");

  // a dropped insert happens only with every byte in use
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == STATUS_FULL |-> text_length == LEN_W'(CAPACITY))
    else $error("full reported below capacity");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(text_length) <= CAPACITY)
    else $error("text length beyond capacity");

endmodule

bind gap_buffer_text_store gbts_checker #(
  .CAPACITY (CAPACITY)
) u_gbts_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .read_byte   (rsp.read_byte),
  .status      (rsp.status),
  .text_length (rsp.text_length),
  .last        (rsp.last)
);
